// File: rtl/core/contact_potential_asinh_assert.svh
// Assertion macros used by the checker file of the contact potential block.
// No dependencies; included by bare file name.
`ifndef CONTACT_POTENTIAL_ASINH_ASSERT_SVH
`define CONTACT_POTENTIAL_ASINH_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define CPA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define CPA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/core/cpa_pkg.sv
// Types and constants for the contact potential asinh block.
// No dependencies; used by the interfaces, the pipeline modules, the top level and the testbench through scoped names.
`timescale 1ns / 1ps

package cpa_pkg;

  localparam int DopW  = 48;
  localparam int RowW  = 10;
  localparam int VoltW = 32;
  localparam int RadW  = 63;
  localparam int RootW = 32;
  localparam int YW    = 49;
  localparam int LogW  = 32;

  // ln 2 in Q0.32.
  localparam logic [31:0] Ln2Q32 = 32'd2977044472;

  typedef enum logic [0:0] {
    REG_SOURCE_VOLTAGE = 1'b0,
    REG_DRAIN_VOLTAGE  = 1'b1
  } reg_idx_e;

  // Sideband carried alongside the square root pipeline.
  typedef struct packed {
    logic            valid;
    logic            func;
    logic [RowW-1:0] row;
    logic            pos;
    logic            big;
    logic [DopW-1:0] mag;
  } sq_side_t;

  // Sideband carried alongside the logarithm pipeline.
  typedef struct packed {
    logic            valid;
    logic            func;
    logic [RowW-1:0] row;
    logic            pos;
  } log_side_t;

endpackage

// File: rtl/core/cpa_in_if.sv
// Input channel of the contact potential block: handshake and item fields.
// Depends on cpa_pkg for the field widths.
`timescale 1ns / 1ps

interface cpa_in_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [cpa_pkg::RowW-1:0]    row;
  logic signed [cpa_pkg::DopW-1:0] doping;

  modport source (output valid, output func, output row, output doping, input ready);
  modport sink (input valid, input func, input row, input doping, output ready);
endinterface

// File: rtl/core/cpa_out_if.sv
// Output channel of the contact potential block: handshake and result fields.
// Depends on cpa_pkg for the field widths.
`timescale 1ns / 1ps

interface cpa_out_if;
  logic                             valid;
  logic                             ready;
  logic [cpa_pkg::RowW-1:0]         row_out;
  logic signed [cpa_pkg::VoltW-1:0] potential;

  modport source (output valid, output row_out, output potential, input ready);
  modport sink (input valid, input row_out, input potential, output ready);
endinterface

// File: rtl/core/cpa_isqrt.sv
// Pipelined integer square root, one result bit per stage, rounding down.
// Depends on cpa_pkg for widths and the sideband type.
`timescale 1ns / 1ps

module cpa_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  cpa_pkg::sq_side_t           side_i,
  input  logic [cpa_pkg::RadW-1:0]    rad_i,
  output cpa_pkg::sq_side_t           side_o,
  output logic [cpa_pkg::RootW-1:0]   root_o
);

  localparam int Steps = cpa_pkg::RootW;

  cpa_pkg::sq_side_t side_q [Steps];
  logic [63:0]       rem_q  [Steps];
  logic [63:0]       res_q  [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);
    logic [63:0]       rem_in;
    logic [63:0]       res_in;
    logic [63:0]       trial;
    cpa_pkg::sq_side_t sd_in;

    if (k == 0) begin : g_first
      assign rem_in = {1'b0, rad_i};
      assign res_in = '0;
      assign sd_in  = side_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign res_in = res_q[k-1];
      assign sd_in  = side_q[k-1];
    end

    assign trial = res_in + Bit;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[k] <= '0;
      end else if (en_i) begin
        side_q[k] <= sd_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_in >= trial) begin
          rem_q[k] <= rem_in - trial;
          res_q[k] <= (res_in >> 1) + Bit;
        end else begin
          rem_q[k] <= rem_in;
          res_q[k] <= res_in >> 1;
        end
      end
    end
  end

  assign side_o = side_q[Steps-1];
  assign root_o = res_q[Steps-1][cpa_pkg::RootW-1:0];

endmodule

// File: rtl/core/cpa_log2.sv
// Pipelined base-2 logarithm: normalising shift stages, then one squaring
// stage per fraction bit. Depends on cpa_pkg for widths and the sideband type.
`timescale 1ns / 1ps

module cpa_log2 (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  cpa_pkg::log_side_t       side_i,
  input  logic [cpa_pkg::YW-1:0]   y_i,
  output cpa_pkg::log_side_t       side_o,
  output logic [cpa_pkg::LogW-1:0] l_o
);

  localparam int NormSteps = 6;
  localparam int FracBits  = 32;

  cpa_pkg::log_side_t nside_q [NormSteps];
  logic [63:0]        x_q     [NormSteps];
  logic [5:0]         s_q     [NormSteps];

  for (genvar j = 0; j < NormSteps; j++) begin : g_norm
    localparam int W = 32 >> j;
    logic [63:0]        x_in;
    logic [5:0]         s_in;
    cpa_pkg::log_side_t sd_in;

    if (j == 0) begin : g_first
      assign x_in  = {y_i, 15'b0};
      assign s_in  = '0;
      assign sd_in = side_i;
    end else begin : g_next
      assign x_in  = x_q[j-1];
      assign s_in  = s_q[j-1];
      assign sd_in = nside_q[j-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        nside_q[j] <= '0;
      end else if (en_i) begin
        nside_q[j] <= sd_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (x_in[63 -: W] == '0) begin
          x_q[j] <= x_in << W;
          s_q[j] <= s_in + 6'(W);
        end else begin
          x_q[j] <= x_in;
          s_q[j] <= s_in;
        end
      end
    end
  end

  cpa_pkg::log_side_t fside_q [FracBits];
  logic [30:0]        m_q     [FracBits];
  logic [31:0]        f_q     [FracBits];
  logic [5:0]         e_q     [FracBits];

  for (genvar k = 0; k < FracBits; k++) begin : g_sq
    logic [30:0]        m_in;
    logic [31:0]        f_in;
    logic [5:0]         e_in;
    logic [61:0]        sqr;
    logic [31:0]        t;
    cpa_pkg::log_side_t sd_in;

    if (k == 0) begin : g_first
      // The top set bit of y sits at 48 - s; the exponent kept is that less 9.
      assign m_in  = x_q[NormSteps-1][63:33];
      assign f_in  = '0;
      assign e_in  = 6'd39 - s_q[NormSteps-1];
      assign sd_in = nside_q[NormSteps-1];
    end else begin : g_next
      assign m_in  = m_q[k-1];
      assign f_in  = f_q[k-1];
      assign e_in  = e_q[k-1];
      assign sd_in = fside_q[k-1];
    end

    assign sqr = 62'(m_in) * 62'(m_in);
    assign t   = sqr[61:30];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        fside_q[k] <= '0;
      end else if (en_i) begin
        fside_q[k] <= sd_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        e_q[k] <= e_in;
        if (t[31]) begin
          m_q[k] <= t[31:1];
          f_q[k] <= {f_in[30:0], 1'b1};
        end else begin
          m_q[k] <= t[30:0];
          f_q[k] <= {f_in[30:0], 1'b0};
        end
      end
    end
  end

  assign side_o = fside_q[FracBits-1];
  assign l_o    = {e_q[FracBits-1], 26'b0} + {6'b0, f_q[FracBits-1][31:6]};

endmodule

// File: rtl/core/contact_potential_asinh.sv
// Top level of the contact potential block; instantiates cpa_isqrt and
// cpa_log2 and uses cpa_pkg, cpa_in_if and cpa_out_if.
`timescale 1ns / 1ps

// Contact potential, asinh(doping/2) plus the selected contact voltage.
// Each item carries a contact selector, a row and a signed Q40.8 doping; its
// result carries the same row and the potential in signed Q16.16, saturated.
// The block is a single pipeline with no feedback: it takes one item in every
// clock cycle while the output slot is free or drains, and each item passes 75
// register stages (input register, squaring, 32 square root stages, a sum
// stage, 6 normalising stages, 32 logarithm squaring stages, the ln 2 scaling
// and the output register). The whole pipeline advances together, so when the
// output is not taken every stage holds and in_i.ready falls; nothing is
// dropped or repeated. Voltages are written through the plain register port
// and are read at the last stage, so they must only be changed while the
// pipeline is empty.
module contact_potential_asinh (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [0:0]                 cfg_idx_i,
  input  logic [cpa_pkg::VoltW-1:0]  cfg_wdata_i,
  cpa_in_if.sink                     in_i,
  cpa_out_if.source                  out_o
);

  logic en;
  logic out_vld_q;

  // One shared advance for every stage: move whenever the output slot is free
  // or is being emptied this cycle.
  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  // Contact voltage registers.
  logic [cpa_pkg::VoltW-1:0] src_v_q;
  logic [cpa_pkg::VoltW-1:0] drn_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_v_q <= '0;
      drn_v_q <= '0;
    end else if (cfg_we_i) begin
      case (cpa_pkg::reg_idx_e'(cfg_idx_i))
        cpa_pkg::REG_SOURCE_VOLTAGE: src_v_q <= cfg_wdata_i;
        cpa_pkg::REG_DRAIN_VOLTAGE:  drn_v_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input stage: magnitude, sign and range class of the doping.
  cpa_pkg::sq_side_t s0_d;
  cpa_pkg::sq_side_t s0_q;
  logic              neg;

  always_comb begin
    neg        = in_i.doping[cpa_pkg::DopW-1];
    s0_d.valid = in_i.valid;
    s0_d.func  = in_i.func;
    s0_d.row   = in_i.row;
    s0_d.mag   = neg ? (~in_i.doping + 1'b1) : in_i.doping;
    s0_d.pos   = !neg && (in_i.doping != '0);
    s0_d.big   = |s0_d.mag[cpa_pkg::DopW-1:31];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q <= '0;
    end else if (en) begin
      s0_q <= s0_d;
    end
  end

  // Radicand A*A + 2^18; only meaningful for magnitudes below 2^31.
  cpa_pkg::sq_side_t            s1_q;
  logic [cpa_pkg::RadW-1:0]     rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else if (en) begin
      s1_q <= s0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q <= 63'(s0_q.mag[30:0]) * 63'(s0_q.mag[30:0]) + 63'd262144;
    end
  end

  cpa_pkg::sq_side_t          s2;
  logic [cpa_pkg::RootW-1:0]  root;

  cpa_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .side_i (s1_q),
    .rad_i  (rad_q),
    .side_o (s2),
    .root_o (root)
  );

  // y = x + sqrt(x*x + 1) in units of 2^-9; for large magnitudes the one
  // under the root falls below resolution and y is simply twice the magnitude.
  cpa_pkg::log_side_t      s3_q;
  logic [cpa_pkg::YW-1:0]  y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_q <= '0;
    end else if (en) begin
      s3_q <= '{valid: s2.valid, func: s2.func, row: s2.row, pos: s2.pos};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (s2.big) begin
        y_q <= {s2.mag, 1'b0};
      end else begin
        y_q <= {18'b0, s2.mag[30:0]} + {17'b0, root};
      end
    end
  end

  cpa_pkg::log_side_t         s4;
  logic [cpa_pkg::LogW-1:0]   l2;

  cpa_log2 u_log2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .side_i (s3_q),
    .y_i    (y_q),
    .side_o (s4),
    .l_o    (l2)
  );

  // Scale log2 in Q.26 by ln 2 in Q0.32.
  cpa_pkg::log_side_t s5_q;
  logic [63:0]        prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_q <= '0;
    end else if (en) begin
      s5_q <= s4;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= 64'(l2) * 64'(cpa_pkg::Ln2Q32);
    end
  end

  // Rounding to Q16.16, sign, voltage add and saturation into the output
  // register.
  logic [63:0]                rounded;
  logic [21:0]                ln_mag;
  logic signed [33:0]         ln_s;
  logic signed [33:0]         v_s;
  logic signed [33:0]         total;
  logic [cpa_pkg::VoltW-1:0]  volt;
  logic [cpa_pkg::VoltW-1:0]  pot_d;
  logic [cpa_pkg::VoltW-1:0]  pot_q;
  logic [cpa_pkg::RowW-1:0]   row_q;

  always_comb begin
    rounded = prod_q + (64'd1 << 41);
    ln_mag  = rounded[63:42];
    ln_s    = s5_q.pos ? $signed({12'b0, ln_mag}) : -$signed({12'b0, ln_mag});
    volt    = s5_q.func ? drn_v_q : src_v_q;
    v_s     = $signed({{2{volt[cpa_pkg::VoltW-1]}}, volt});
    total   = ln_s + v_s;
    if (total > 34'sh07FFFFFFF) begin
      pot_d = 32'h7FFF_FFFF;
    end else if (total < -34'sh080000000) begin
      pot_d = 32'h8000_0000;
    end else begin
      pot_d = total[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= s5_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pot_q <= pot_d;
      row_q <= s5_q.row;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.potential = pot_q;
  assign out_o.row_out   = row_q;

endmodule

// File: rtl/core/cpa_checker.sv
// Port-level checker for the contact potential block, bound to its top level.
// Depends on cpa_in_if, cpa_out_if and contact_potential_asinh_assert.svh.
`timescale 1ns / 1ps
`include "contact_potential_asinh_assert.svh"

module cpa_checker (
  input logic       clk_i,
  input logic       rst_ni,
  cpa_in_if.sink    in_i,
  cpa_out_if.source out_o
);

  // A result that is not taken stays offered and unchanged.
  `CPA_ASSERT(a_out_hold, clk_i, rst_ni, out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.potential) && $stable(out_o.row_out), "result changed while stalled")

  // Input ready is high exactly when the output slot is free or drains.
  `CPA_ASSERT(a_ready_link, clk_i, rst_ni, in_i.ready == (!out_o.valid || out_o.ready), "input ready does not follow output")

  // Reset empties the pipeline.
  `CPA_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> !out_o.valid, "result offered during reset")

endmodule

bind contact_potential_asinh cpa_checker u_cpa_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .out_o  (out_o)
);

// File: bench/tb_top.sv
// Self-checking testbench of contact_potential_asinh: random and directed items.
// Depends on cpa_pkg, cpa_in_if, cpa_out_if and the block itself.
`timescale 1ns / 1ps

module tb_top;

  // Holds the contact voltages and the queue of potentials still to come.
  class potential_board;
    logic [cpa_pkg::VoltW-1:0] src_volt, drn_volt;
    logic [cpa_pkg::RowW+cpa_pkg::VoltW-1:0] awaited[$];
    int mismatches;

    function new();
      src_volt = '0;
      drn_volt = '0;
      mismatches = 0;
    endfunction

    function logic [63:0] floor_root(logic [63:0] n);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // ln(x + sqrt(x*x + 1)) in Q16.16, for x half of a magnitude in Q40.8 units.
    function logic [63:0] ln_of_mag(logic [63:0] a);
      logic [63:0] y, m, frac, l;
      int p;
      frac = 0;
      p = 0;
      if (a < (64'd1 << 31)) y = a + floor_root(a * a + (64'd1 << 18));
      else y = a << 1;
      for (int i = 0; i < 64; i++) if (y[i]) p = i;
      if (p >= 30) m = y >> (p - 30);
      else m = y << (30 - p);
      for (int i = 0; i < 32; i++) begin
        m = (m * m) >> 30;
        frac = frac << 1;
        if (m >= (64'd1 << 31)) begin
          frac[0] = 1'b1;
          m = m >> 1;
        end
      end
      l = (64'(p >= 9 ? p - 9 : 0) << 26) + (frac >> 6);
      return (l * 64'(cpa_pkg::Ln2Q32) + (64'd1 << 41)) >> 42;
    endfunction

    function void note_input(logic func, logic [cpa_pkg::RowW-1:0] row,
                             logic [cpa_pkg::DopW-1:0] dop);
      logic [cpa_pkg::DopW-1:0] amag;
      logic [63:0] a;
      longint sum, volt;
      amag = dop[cpa_pkg::DopW-1] ? (~dop + 1'b1) : dop;
      a = 64'(amag);
      sum = longint'(ln_of_mag(a));
      if (dop[cpa_pkg::DopW-1] || dop == '0) sum = -sum;
      volt = func ? longint'(signed'(drn_volt)) : longint'(signed'(src_volt));
      sum = sum + volt;
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      awaited.push_back({row, sum[31:0]});
    endfunction

    function void check_result(logic [cpa_pkg::RowW-1:0] row,
                               logic [cpa_pkg::VoltW-1:0] pot);
      logic [cpa_pkg::RowW+cpa_pkg::VoltW-1:0] exp_item;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: row %0d potential %h", row, pot);
        return;
      end
      exp_item = awaited.pop_front();
      if (exp_item[cpa_pkg::RowW+cpa_pkg::VoltW-1:cpa_pkg::VoltW] != row ||
          exp_item[cpa_pkg::VoltW-1:0] != pot) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected row %0d potential %h, got row %0d potential %h",
                   exp_item[cpa_pkg::RowW+cpa_pkg::VoltW-1:cpa_pkg::VoltW],
                   exp_item[cpa_pkg::VoltW-1:0], row, pot);
      end
    endfunction
  endclass

  localparam int CycleLimit = 200000;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [0:0]                cfg_idx_i = cpa_pkg::REG_SOURCE_VOLTAGE;
  logic [cpa_pkg::VoltW-1:0] cfg_wdata_i = '0;

  cpa_in_if  in_ch();
  cpa_out_if out_ch();

  contact_potential_asinh dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_ch.sink),
    .out_o      (out_ch.source)
  );

  potential_board board = new();
  int  send_idle_pct, recv_idle_pct;
  bit  in_taken;
  int  cycles;

  // Clock with a period of 8 ns.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = 1'b0;
    in_ch.row = '0;
    in_ch.doping = '0;
    out_ch.ready = 1'b0;
  end

  // Sample both handshakes at the rising edge; values seen here are those
  // settled before the edge, so the order of events does not matter.
  always @(posedge clk_i) begin
    in_taken = in_ch.valid && in_ch.ready;
    if (in_taken) board.note_input(in_ch.func, in_ch.row, in_ch.doping);
    if (out_ch.valid && out_ch.ready) board.check_result(out_ch.row_out, out_ch.potential);
  end

  // The receiver stalls at random, at a rate set per phase.
  always @(negedge clk_i) begin
    if (rst_ni) out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Offers one item and returns at the falling edge after it was taken.
  task automatic send_item(logic func, logic [cpa_pkg::RowW-1:0] row,
                           logic [cpa_pkg::DopW-1:0] dop);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid = 1'b1;
    in_ch.func = func;
    in_ch.row = row;
    in_ch.doping = dop;
    do @(negedge clk_i); while (!in_taken);
  endtask

  // Leaves the channel idle and waits until every result has come back.
  task automatic drain_pipe();
    in_ch.valid = 1'b0;
    while (board.awaited.size() != 0) @(negedge clk_i);
  endtask

  // Register writes happen only with the pipeline empty.
  task automatic write_volt(cpa_pkg::reg_idx_e idx, logic [cpa_pkg::VoltW-1:0] value);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == cpa_pkg::REG_SOURCE_VOLTAGE) board.src_volt = value;
    else board.drn_volt = value;
  endtask

  function automatic logic [cpa_pkg::DopW-1:0] pick_doping();
    int kind;
    logic [63:0] r;
    kind = $urandom_range(99);
    r = {$urandom, $urandom};
    if (kind < 35) r = 64'($urandom_range(4095));
    else if (kind < 55) r = r & 64'h7FFF_FFFF;
    else if (kind < 65) r = 64'(32'h7FFF_FFF0 + $urandom_range(31));
    else if (kind < 70) begin
      case ($urandom_range(3))
        0: r = 64'h7FFF_FFFF_FFFF;
        1: r = 64'h8000_0000_0000;
        2: r = 0;
        default: r = 1;
      endcase
    end
    if (kind < 65 && $urandom_range(1)) r = -r;
    return r[cpa_pkg::DopW-1:0];
  endfunction

  // Short directed run over the edges of the doping range and both contacts.
  task automatic directed_items();
    logic [cpa_pkg::DopW-1:0] dops[12];
    dops = '{48'd0, 48'd1, -48'sd1, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000,
             48'h7FFF_FFFF, 48'h8000_0000, -48'sh8000_0000, -48'sh7FFF_FFFF,
             48'd512, -48'sd512, 48'h0000_0010_0000};
    foreach (dops[i]) send_item(i[0], (i % 3 == 0) ? 10'd1023 : 10'(i), dops[i]);
  endtask

  task automatic random_items(int count);
    repeat (count) send_item($urandom_range(1), 10'($urandom_range(1023)), pick_doping());
  endtask

  initial begin
    cycles = 0;
    send_idle_pct = 16;
    recv_idle_pct = 57;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset voltages of zero, then the saturating extremes.
    directed_items();
    drain_pipe();
    write_volt(cpa_pkg::REG_SOURCE_VOLTAGE, 32'h7FFF_FFFF);
    write_volt(cpa_pkg::REG_DRAIN_VOLTAGE, 32'h8000_0000);
    directed_items();
    random_items(100);
    drain_pipe();

    write_volt(cpa_pkg::REG_SOURCE_VOLTAGE, $urandom);
    write_volt(cpa_pkg::REG_DRAIN_VOLTAGE, $urandom);
    random_items(350);
    drain_pipe();

    send_idle_pct = 57;
    recv_idle_pct = 16;
    write_volt(cpa_pkg::REG_SOURCE_VOLTAGE, 32'h0);
    write_volt(cpa_pkg::REG_DRAIN_VOLTAGE, 32'h0001_0000);
    random_items(450);
    drain_pipe();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_volt(cpa_pkg::REG_SOURCE_VOLTAGE, 32'h8000_0000);
    write_volt(cpa_pkg::REG_DRAIN_VOLTAGE, 32'h7FFF_FFFF);
    random_items(200);
    drain_pipe();
    write_volt(cpa_pkg::REG_SOURCE_VOLTAGE, $urandom);
    write_volt(cpa_pkg::REG_DRAIN_VOLTAGE, $urandom);
    random_items(230);
    drain_pipe();

    // Let the latency pass so a stray result would still be caught.
    repeat (100) @(negedge clk_i);
    if (board.mismatches == 0 && board.awaited.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
